### rtl/geu_pkg.sv
// ----------------------------------------------------------------------------
// geu_pkg
// Shared widths, command/status types and saturation helper for the gravity
// Euler step core.
// ----------------------------------------------------------------------------
package geu_pkg;

	// Q format
	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;

	// iterative divider: dividend holds a<<F, m*u and rem<<F
	localparam int DVD_W = DW + FRAC_BITS + 1;
	localparam int DVS_W = DW + 1;
	localparam int DCNT_W = $clog2(DVD_W);

	// square root of a 64-bit radicand
	localparam int RAD_W   = 2 * DW;
	localparam int ROOT_W  = DW;
	localparam int SCNT_W  = $clog2(ROOT_W);

	// first quotient is at most a bit above 1.0
	localparam int U_W = FRAC_BITS + 1;

	localparam logic [DW-1:0] PULL_CAP = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] GAIN_RST = DW'(1) << FRAC_BITS;

	// configuration register indexes
	localparam logic [2:0] CFG_GAIN = 3'd0;
	localparam logic [2:0] CFG_X    = 3'd1;
	localparam logic [2:0] CFG_Y    = 3'd2;
	localparam logic [2:0] CFG_VX   = 3'd3;
	localparam logic [2:0] CFG_VY   = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIFF,
		OP_SQUARE,
		OP_HALF,
		OP_SQRT,
		OP_DIV_U,
		OP_MUL,
		OP_DIV_W,
		OP_DIV_Q,
		OP_DIV_T,
		OP_ACC,
		OP_GAIN,
		OP_VEL,
		OP_POS
	} op_t;

	typedef struct packed {
		logic accept;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic counted;
		logic zero;
		logic ovf;
		logic last;
		logic sqrt_done;
		logic div_done;
	} sts_t;

	// clamp a 34-bit signed value to signed 32 bits
	function automatic logic signed [DW-1:0] sat32(input logic signed [DW+1:0] v);
		logic signed [DW-1:0] r;
		if (v > 34'sd2147483647)
			r = {1'b0, {(DW-1){1'b1}}};
		else if (v < -34'sd2147483648)
			r = {1'b1, {(DW-1){1'b0}}};
		else
			r = v[DW-1:0];
		return r;
	endfunction

endpackage

### rtl/geu_div.sv
// ----------------------------------------------------------------------------
// geu_div
// Restoring divider, one quotient bit per cycle. Quotient and remainder hold
// after done until the next start.
// ----------------------------------------------------------------------------
module geu_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [geu_pkg::DVD_W-1:0]  dividend,
	input  logic [geu_pkg::DVS_W-1:0]  divisor,
	output logic [geu_pkg::DVD_W-1:0]  quotient,
	output logic [geu_pkg::DVS_W-1:0]  remainder,
	output logic                       done
);
	import geu_pkg::*;

	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fit;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fit};
			rem_q <= fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

### rtl/geu_sqrt.sv
// ----------------------------------------------------------------------------
// geu_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module geu_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [geu_pkg::RAD_W-1:0]   radicand,
	output logic [geu_pkg::ROOT_W-1:0]  root,
	output logic                        done
);
	import geu_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W+2:0] nxt;
	logic [ROOT_W+2:0] trial;
	logic              fit;

	// bring down two radicand bits, trial subtract 4*root+1
	assign nxt   = {rem_q[ROOT_W:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fit   = nxt >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SCNT_W'(ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder can reach twice the root, so it keeps 33 significant bits
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fit ? (ROOT_W+2)'(nxt - trial) : nxt[ROOT_W+1:0];
			root_q <= {root_q[ROOT_W-2:0], fit};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

### rtl/geu_datapath.sv
// ----------------------------------------------------------------------------
// geu_datapath
// Body state, acceleration sums and the arithmetic for one gravity step:
// squares, root, four divides per component, gain scaling and Euler update.
// ----------------------------------------------------------------------------
module geu_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  geu_pkg::cmd_t              cmd,
	output geu_pkg::sts_t              sts,
	input  logic signed [31:0]         other_x,
	input  logic signed [31:0]         other_y,
	input  logic [31:0]                other_mass,
	input  logic                       attracts,
	input  logic                       is_self,
	input  logic                       last_body,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_idx,
	input  logic [31:0]                cfg_data,
	output logic signed [31:0]         new_x,
	output logic signed [31:0]         new_y,
	output logic signed [31:0]         new_vx,
	output logic signed [31:0]         new_vy
);
	import geu_pkg::*;

	// body state and sums
	logic [DW-1:0]        gain_q;
	logic signed [DW-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q, acc_x_q, acc_y_q;

	// item and per-body working registers
	logic signed [DW-1:0] ox_q, oy_q;
	logic [DW-1:0]        m_q;
	logic                 counted_q, last_q, half_q;
	logic                 negx_q, negy_q;
	logic [DW-1:0]        ax_q, ay_q;
	logic [RAD_W-1:0]     sqx_q, sqy_q;
	logic [DVS_W-1:0]     r_q;
	logic [DVD_W-1:0]     vx_q, vy_q, qx_q, qy_q;
	logic [RAD_W-1:0]     gpx_q, gpy_q;

	logic signed [DW:0]   dx, dy;
	logic [DW-1:0]        opx, opy;
	logic [RAD_W:0]       sq_sum;
	logic [ROOT_W-1:0]    root;
	logic                 sqrt_done;
	logic [DVS_W-1:0]     r_new, dvs;
	logic [DVD_W-1:0]     dvd_x, dvd_y, quo_x, quo_y;
	logic [DVS_W-1:0]     rem_x, rem_y;
	logic                 done_x, done_y;
	logic                 div_go;
	logic signed [DW-1:0] dv_x, dv_y, vel_x_n, vel_y_n;

	// magnitude of the pull from quotient and fraction quotient, capped
	function automatic logic [DW-1:0] pull_mag(input logic [DVD_W-1:0] q,
			input logic [DVD_W-1:0] t);
		logic [DVD_W-1:0] s;
		logic [DW-1:0]    r;
		s = {1'b0, q[DW-1:0], {FRAC_BITS{1'b0}}} + t;
		if (q[DVD_W-1:DW] != '0 || s > DVD_W'(PULL_CAP))
			r = PULL_CAP;
		else
			r = s[DW-1:0];
		return r;
	endfunction

	function automatic logic signed [DW-1:0] add_pull(input logic signed [DW-1:0] acc,
			input logic neg, input logic [DW-1:0] f);
		logic signed [DW+1:0] fs;
		fs = neg ? -$signed({2'b00, f}) : $signed({2'b00, f});
		return sat32({{2{acc[DW-1]}}, acc} + fs);
	endfunction

	// |acc| * gain product, scaled, capped at 2^31 and signed
	function automatic logic signed [DW-1:0] scale_dv(input logic [RAD_W-1:0] p,
			input logic neg);
		logic [RAD_W-FRAC_BITS-1:0] sh;
		logic [DW:0]                c;
		logic signed [DW+1:0]       s;
		sh = p[RAD_W-1:FRAC_BITS];
		if (sh > (RAD_W-FRAC_BITS)'(33'h1_0000_0000 >> 1))
			c = {2'b01, {(DW-1){1'b0}}};
		else
			c = sh[DW:0];
		s = neg ? -$signed({1'b0, c}) : $signed({1'b0, c});
		return sat32(s);
	endfunction

	function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	// difference to the other body
	assign dx = {ox_q[DW-1], ox_q} - {pos_x_q[DW-1], pos_x_q};
	assign dy = {oy_q[DW-1], oy_q} - {pos_y_q[DW-1], pos_y_q};

	// squares and overflow check of their sum
	assign opx    = half_q ? (ax_q >> 1) : ax_q;
	assign opy    = half_q ? (ay_q >> 1) : ay_q;
	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	assign r_new = half_q ? {root, 1'b0} : {1'b0, root};

	// divider operand selection
	always_comb begin
		dvs    = r_q;
		dvd_x  = vx_q;
		dvd_y  = vy_q;
		div_go = 1'b0;
		case (cmd.op)
			OP_DIV_U: begin
				dvs    = r_new;
				dvd_x  = {1'b0, ax_q, {FRAC_BITS{1'b0}}};
				dvd_y  = {1'b0, ay_q, {FRAC_BITS{1'b0}}};
				div_go = 1'b1;
			end
			OP_DIV_W: begin
				div_go = 1'b1;
			end
			OP_DIV_Q: begin
				dvd_x  = quo_x;
				dvd_y  = quo_y;
				div_go = 1'b1;
			end
			OP_DIV_T: begin
				dvd_x  = {rem_x, {FRAC_BITS{1'b0}}};
				dvd_y  = {rem_y, {FRAC_BITS{1'b0}}};
				div_go = 1'b1;
			end
			default: begin
				div_go = 1'b0;
			end
		endcase
	end

	geu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT),
		.radicand (sq_sum[RAD_W-1:0]),
		.root     (root),
		.done     (sqrt_done)
	);

	geu_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (dvd_x),
		.divisor   (dvs),
		.quotient  (quo_x),
		.remainder (rem_x),
		.done      (done_x)
	);

	geu_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (dvd_y),
		.divisor   (dvs),
		.quotient  (quo_y),
		.remainder (rem_y),
		.done      (done_y)
	);

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ox_q      <= other_x;
			oy_q      <= other_y;
			m_q       <= other_mass;
			counted_q <= attracts & ~is_self;
			last_q    <= last_body;
		end
		case (cmd.op)
			OP_DIFF: begin
				negx_q <= dx[DW];
				negy_q <= dy[DW];
				ax_q   <= dx[DW] ? DW'(-dx) : DW'(dx);
				ay_q   <= dy[DW] ? DW'(-dy) : DW'(dy);
				half_q <= 1'b0;
			end
			OP_SQUARE: begin
				sqx_q <= RAD_W'(opx) * RAD_W'(opx);
				sqy_q <= RAD_W'(opy) * RAD_W'(opy);
			end
			OP_HALF: begin
				half_q <= 1'b1;
			end
			OP_DIV_U: begin
				r_q <= r_new;
			end
			OP_MUL: begin
				vx_q <= DVD_W'(m_q) * DVD_W'(quo_x[U_W-1:0]);
				vy_q <= DVD_W'(m_q) * DVD_W'(quo_y[U_W-1:0]);
			end
			OP_DIV_T: begin
				qx_q <= quo_x;
				qy_q <= quo_y;
			end
			OP_GAIN: begin
				gpx_q <= mag32(acc_x_q) * gain_q;
				gpy_q <= mag32(acc_y_q) * gain_q;
			end
			default: begin
				half_q <= half_q;
			end
		endcase
	end

	// Euler update values
	assign dv_x    = scale_dv(gpx_q, acc_x_q[DW-1]);
	assign dv_y    = scale_dv(gpy_q, acc_y_q[DW-1]);
	assign vel_x_n = sat32({{2{vel_x_q[DW-1]}}, vel_x_q} + {{2{dv_x[DW-1]}}, dv_x});
	assign vel_y_n = sat32({{2{vel_y_q[DW-1]}}, vel_y_q} + {{2{dv_y[DW-1]}}, dv_y});

	// body state, sums and gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GAIN: gain_q  <= cfg_data;
				CFG_X:    pos_x_q <= cfg_data;
				CFG_Y:    pos_y_q <= cfg_data;
				CFG_VX:   vel_x_q <= cfg_data;
				CFG_VY:   vel_y_q <= cfg_data;
				default:  gain_q  <= gain_q;
			endcase
		end else begin
			case (cmd.op)
				OP_ACC: begin
					acc_x_q <= add_pull(acc_x_q, negx_q, pull_mag(qx_q, quo_x));
					acc_y_q <= add_pull(acc_y_q, negy_q, pull_mag(qy_q, quo_y));
				end
				OP_VEL: begin
					vel_x_q <= vel_x_n;
					vel_y_q <= vel_y_n;
				end
				OP_POS: begin
					pos_x_q <= sat32({{2{pos_x_q[DW-1]}}, pos_x_q} +
							{{2{vel_x_q[DW-1]}}, vel_x_q});
					pos_y_q <= sat32({{2{pos_y_q[DW-1]}}, pos_y_q} +
							{{2{vel_y_q[DW-1]}}, vel_y_q});
					acc_x_q <= '0;
					acc_y_q <= '0;
				end
				default: begin
					acc_x_q <= acc_x_q;
				end
			endcase
		end
	end

	// status to the controller
	assign sts.counted   = counted_q;
	assign sts.zero      = (ax_q == '0) && (ay_q == '0);
	assign sts.ovf       = sq_sum[RAD_W];
	assign sts.last      = last_q;
	assign sts.sqrt_done = sqrt_done;
	assign sts.div_done  = done_x & done_y;

	assign new_x  = pos_x_q;
	assign new_y  = pos_y_q;
	assign new_vx = vel_x_q;
	assign new_vy = vel_y_q;

endmodule

### rtl/geu_ctrl.sv
// ----------------------------------------------------------------------------
// geu_ctrl
// Sequencer for one item: distance, root, the four divide rounds, sum update
// and, on the last body, the Euler update and the result strobe.
// ----------------------------------------------------------------------------
module geu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  geu_pkg::sts_t  sts,
	output geu_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);
	import geu_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_EVAL, S_SQ, S_CHK, S_HALF, S_SQRT, S_SQRTW,
		S_DU, S_DUW, S_MUL, S_DW, S_DWW, S_DQ, S_DQW, S_DT, S_DTW,
		S_ACC, S_FIN, S_GAIN, S_VEL, S_POS
	} state_t;

	state_t state_q, nxt;
	op_t    op_q, op_n;
	logic   done_q;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	// next state
	always_comb begin
		nxt = state_q;
		case (state_q)
			S_IDLE:  if (start) nxt = S_DIFF;
			S_DIFF:  nxt = S_EVAL;
			S_EVAL:  nxt = (sts.counted && !sts.zero) ? S_SQ : S_FIN;
			S_SQ:    nxt = S_CHK;
			S_CHK:   nxt = sts.ovf ? S_HALF : S_SQRT;
			S_HALF:  nxt = S_SQ;
			S_SQRT:  nxt = S_SQRTW;
			S_SQRTW: if (sts.sqrt_done) nxt = S_DU;
			S_DU:    nxt = S_DUW;
			S_DUW:   if (sts.div_done) nxt = S_MUL;
			S_MUL:   nxt = S_DW;
			S_DW:    nxt = S_DWW;
			S_DWW:   if (sts.div_done) nxt = S_DQ;
			S_DQ:    nxt = S_DQW;
			S_DQW:   if (sts.div_done) nxt = S_DT;
			S_DT:    nxt = S_DTW;
			S_DTW:   if (sts.div_done) nxt = S_ACC;
			S_ACC:   nxt = S_FIN;
			S_FIN:   nxt = sts.last ? S_GAIN : S_IDLE;
			S_GAIN:  nxt = S_VEL;
			S_VEL:   nxt = S_POS;
			S_POS:   nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	// operation carried out while in a state
	always_comb begin
		case (nxt)
			S_DIFF:  op_n = OP_DIFF;
			S_SQ:    op_n = OP_SQUARE;
			S_HALF:  op_n = OP_HALF;
			S_SQRT:  op_n = OP_SQRT;
			S_DU:    op_n = OP_DIV_U;
			S_MUL:   op_n = OP_MUL;
			S_DW:    op_n = OP_DIV_W;
			S_DQ:    op_n = OP_DIV_Q;
			S_DT:    op_n = OP_DIV_T;
			S_ACC:   op_n = OP_ACC;
			S_GAIN:  op_n = OP_GAIN;
			S_VEL:   op_n = OP_VEL;
			S_POS:   op_n = OP_POS;
			default: op_n = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			done_q  <= 1'b0;
		end else begin
			state_q <= nxt;
			op_q    <= op_n;
			done_q  <= (state_q == S_POS);
		end
	end

	assign cmd.accept = accept;
	assign cmd.op     = op_q;
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;

	// result strobe only once the item is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DIFF && op_q == OP_DIFF))
		else $error("accepted item not started");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DUW || state_q == S_DWW ||
			state_q == S_DQW || state_q == S_DTW))
		else $error("divider finished outside a wait state");

	a_sqrt_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sqrt_done |-> state_q == S_SQRTW)
		else $error("root finished outside its wait state");

endmodule

### rtl/gravity_euler_step_core.sv
// ----------------------------------------------------------------------------
// gravity_euler_step_core
// 2-D Newtonian gravity Euler step for one body in signed Q16.16.
// ----------------------------------------------------------------------------
// One item is taken at a time: start is accepted while busy is low. A body
// that attracts and is not this body runs the dividers four times in a row
// (x and y share the rounds on two dividers) after the square root; a
// skipped body goes straight to the end of the item. On the last body of a
// tick the core then applies the gain and the Euler update; the result is
// then shown for one cycle with done high and must be taken then. The user
// must make configuration writes while busy is low; it is not enforced.
module gravity_euler_step_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic signed [31:0] other_x,
	input  logic signed [31:0] other_y,
	input  logic [31:0]        other_mass,
	input  logic               attracts,
	input  logic               is_self,
	input  logic               last_body,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_vx,
	output logic signed [31:0] new_vy
);
	import geu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	geu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	geu_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.other_x    (other_x),
		.other_y    (other_y),
		.other_mass (other_mass),
		.attracts   (attracts),
		.is_self    (is_self),
		.last_body  (last_body),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.new_x      (new_x),
		.new_y      (new_y),
		.new_vx     (new_vx),
		.new_vy     (new_vy)
	);

endmodule

### test/gravity_euler_step_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_euler_step_core_chk
// Watches the item, result and register ports of the gravity Euler step core.
// It keeps its own copy of the body state, works out the new position and
// speed for each tick and compares them with what the core shows on done.
// ----------------------------------------------------------------------------
module gravity_euler_step_core_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [31:0] other_x,
	input  logic [31:0] other_y,
	input  logic [31:0] other_mass,
	input  logic        attracts,
	input  logic        is_self,
	input  logic        last_body,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic [31:0] new_x,
	input  logic [31:0] new_y,
	input  logic [31:0] new_vx,
	input  logic [31:0] new_vy,
	output int          errors,
	output int          pending
);
	import geu_pkg::*;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] vx;
		logic [31:0] vy;
	} body_t;

	body_t tick_q[$];

	longint unsigned gain;
	longint          px, py, vx, vy, sum_x, sum_y;

	localparam longint MAX32 = 64'sh7FFFFFFF;
	localparam longint MIN32 = -64'sh80000000;

	function automatic longint clamp32(input longint v);
		if (v > MAX32) return MAX32;
		if (v < MIN32) return MIN32;
		return v;
	endfunction

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// one pull component: a*m/r^3 in Q.F, capped
	function automatic longint unsigned pull_mag(input longint unsigned a,
			input longint unsigned m, input longint unsigned r);
		longint unsigned u, w, q, rm, f;
		u = (a << FRAC_BITS) / r;
		w = (m * u) / r;
		q = w / r;
		rm = w % r;
		if (q >= (64'd1 << 32)) return 64'h7FFFFFFF;
		f = (q << FRAC_BITS) + ((rm << FRAC_BITS) / r);
		return (f > 64'h7FFFFFFF) ? 64'h7FFFFFFF : f;
	endfunction

	function automatic longint gain_step(input longint acc);
		longint unsigned p;
		p = ((acc < 0 ? -acc : acc) * gain) >> FRAC_BITS;
		if (p > 64'h80000000) p = 64'h80000000;
		return clamp32(acc < 0 ? -longint'(p) : longint'(p));
	endfunction

	// add one body's pull into the sums
	task automatic add_body(input longint ox, input longint oy, input longint unsigned m);
		longint          dx, dy;
		longint unsigned ax, ay, sq, r;
		dx = ox - px;
		dy = oy - py;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (ax == 0 && ay == 0) return;
		sq = ax * ax + ay * ay;
		if (sq < ax * ax)
			r = 2 * root64((ax >> 1) * (ax >> 1) + (ay >> 1) * (ay >> 1));
		else
			r = root64(sq);
		if (r == 0) return;
		sum_x = clamp32(sum_x + (dx < 0 ? -longint'(pull_mag(ax, m, r))
			: longint'(pull_mag(ax, m, r))));
		sum_y = clamp32(sum_y + (dy < 0 ? -longint'(pull_mag(ay, m, r))
			: longint'(pull_mag(ay, m, r))));
	endtask

	assign pending = tick_q.size();

	always @(posedge clk or negedge arst_n) begin
		body_t b;
		if (!arst_n) begin
			gain = 65536;
			px = 0; py = 0; vx = 0; vy = 0;
			sum_x = 0; sum_y = 0;
			tick_q.delete();
			errors = 0;
		end else begin
			// result check
			if (done) begin
				if (tick_q.size() == 0) begin
					$display("%0t: result with none expected: x=%h y=%h vx=%h vy=%h",
						$time, new_x, new_y, new_vx, new_vy);
					errors++;
				end else begin
					b = tick_q.pop_front();
					if (new_x !== b.x) begin
						$display("%0t: new_x expected %h actual %h", $time, b.x, new_x);
						errors++;
					end
					if (new_y !== b.y) begin
						$display("%0t: new_y expected %h actual %h", $time, b.y, new_y);
						errors++;
					end
					if (new_vx !== b.vx) begin
						$display("%0t: new_vx expected %h actual %h", $time, b.vx, new_vx);
						errors++;
					end
					if (new_vy !== b.vy) begin
						$display("%0t: new_vy expected %h actual %h", $time, b.vy, new_vy);
						errors++;
					end
				end
			end
			// register writes load state at once
			if (cfg_we) begin
				case (cfg_idx)
					CFG_GAIN: gain = cfg_data;
					CFG_X:    px = longint'($signed(cfg_data));
					CFG_Y:    py = longint'($signed(cfg_data));
					CFG_VX:   vx = longint'($signed(cfg_data));
					CFG_VY:   vy = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			// accepted item
			if (start && !busy) begin
				if (attracts && !is_self)
					add_body(longint'($signed(other_x)), longint'($signed(other_y)),
						longint'(other_mass));
				if (last_body) begin
					vx = clamp32(vx + gain_step(sum_x));
					vy = clamp32(vy + gain_step(sum_y));
					px = clamp32(px + vx);
					py = clamp32(py + vy);
					sum_x = 0;
					sum_y = 0;
					b.x = px[31:0]; b.y = py[31:0];
					b.vx = vx[31:0]; b.vy = vy[31:0];
					tick_q.push_back(b);
				end
			end
		end
	end

	final begin
		if (tick_q.size() != 0)
			$display("%0t: %0d results never arrived", $time, tick_q.size());
	end

endmodule

### test/gravity_euler_step_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_euler_step_core_tb
// Drives bodies and register writes into the gravity Euler step core: a
// directed set of edge cases, then random ticks over several register
// settings and sender gap rates. The checker predicts and compares.
// ----------------------------------------------------------------------------
module gravity_euler_step_core_tb;
	import geu_pkg::*;

	localparam int SETTLE = 400;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic [31:0] other_x, other_y, other_mass;
	logic        attracts, is_self, last_body;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;
	logic [31:0] new_x, new_y, new_vx, new_vy;
	int          errors;
	int          pending;
	int          gap_pct;

	gravity_euler_step_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.other_x(other_x), .other_y(other_y), .other_mass(other_mass),
		.attracts(attracts), .is_self(is_self), .last_body(last_body),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.new_x(new_x), .new_y(new_y), .new_vx(new_vx), .new_vy(new_vy)
	);

	gravity_euler_step_core_chk chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.other_x(other_x), .other_y(other_y), .other_mass(other_mass),
		.attracts(attracts), .is_self(is_self), .last_body(last_body),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.new_x(new_x), .new_y(new_y), .new_vx(new_vx), .new_vy(new_vy),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// present one item, return on the edge that takes it
	task automatic send_body(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] m, input logic att, input logic slf, input logic lst);
		int gap;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			gap = $urandom_range(8, 1);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		other_x <= x; other_y <= y; other_mass <= m;
		attracts <= att; is_self <= slf; last_body <= lst;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// register write with the core drained
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_regs(input logic [31:0] g, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] vx0, input logic [31:0] vy0);
		write_reg(CFG_GAIN, g);
		write_reg(CFG_X, x);
		write_reg(CFG_Y, y);
		write_reg(CFG_VX, vx0);
		write_reg(CFG_VY, vy0);
	endtask

	function automatic logic [31:0] coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h00200000) - 32'h00100000;
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	function automatic logic [31:0] mass();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'hFFFFFFFF;
			default: return $urandom_range(32'h000A0000);
		endcase
	endfunction

	initial begin
		int n, len;
		arst_n = 1'b0;
		start = 1'b0;
		other_x = '0; other_y = '0; other_mass = '0;
		attracts = 1'b0; is_self = 1'b0; last_body = 1'b0;
		cfg_we = 1'b0; cfg_idx = CFG_GAIN; cfg_data = '0;
		gap_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: from reset values, then extremes
		send_body(32'h00010000, 32'h0, 32'h00010000, 1'b1, 1'b0, 1'b1);
		send_body(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0);
		send_body(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1);
		send_body(32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 1'b0);
		send_body(32'h00000005, 32'h00000003, 32'h00000000, 1'b0, 1'b0, 1'b1);
		// zero distance: body sits on this one
		load_regs(32'h00020000, 32'h00640000, 32'hFFCE0000, 32'h0, 32'h0);
		send_body(32'h00640000, 32'hFFCE0000, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0);
		send_body(32'h00650000, 32'hFFCE0000, 32'h00050000, 1'b1, 1'b0, 1'b1);
		// huge gain and speed run into saturation
		load_regs(32'hFFFFFFFF, 32'h7FFF0000, 32'h80010000, 32'h7FFFFFFF, 32'h80000000);
		send_body(32'h7FFF0001, 32'h80010000, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1);
		send_body(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1);
		send_body(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1);
		// zero gain, ignored register indexes
		load_regs(32'h0, 32'h0, 32'h0, 32'h00008000, 32'hFFFF8000);
		write_reg(3'd5, 32'hFFFFFFFF);
		write_reg(3'd6, 32'h12345678);
		write_reg(3'd7, 32'hFFFFFFFF);
		send_body(32'h00000001, 32'h00000001, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1);

		// random ticks over settings and gap rates
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_regs(32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0);
				1: load_regs($urandom, coord(), coord(), $urandom, $urandom);
				2: load_regs(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
				3: load_regs(32'h0, coord(), coord(), coord(), coord());
				4: load_regs($urandom_range(32'h00040000), coord(), coord(), 32'h0, 32'h0);
				default: load_regs(32'h00008000, 32'h7FFFFFFF, 32'h80000000,
					32'h80000000, 32'h7FFFFFFF);
			endcase
			gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 56 : 36;
			n = 0;
			while (n < 208) begin
				len = $urandom_range(5, 1);
				for (int k = 0; k < len; k++) begin
					send_body(coord(), coord(), mass(), $urandom_range(9) != 0,
						$urandom_range(9) == 0, k == len - 1);
					n++;
				end
			end
		end

		start <= 1'b0;
		fork
			begin
				do @(negedge clk); while (pending != 0);
			end
			begin
				#60000000;
				$display("tb: failure");
				$finish;
			end
		join_any
		disable fork;
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// hard stop if the core hangs
	initial begin
		#80000000;
		$display("tb: failure");
		$finish;
	end

endmodule
